@@ src/vehicle_lamp_siren_sequencer_top_macros.svh @@
// Assertion macros for the lamp and siren sequencer.
// Used by vehicle_lamp_siren_sequencer_top; needs clk and rst in scope.
`ifndef VEHICLE_LAMP_SIREN_SEQUENCER_TOP_MACROS_SVH
`define VEHICLE_LAMP_SIREN_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTH
`define VLSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VLSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VLSS_ASSERT_SAME(lbl, ante, cons, msg)
`define VLSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/vlss_pkg.sv @@
// Package for the lamp and siren sequencer: beat types, turn codes, compare points.
// No dependencies.
package vlss_pkg;

  typedef struct packed {
    logic       hazard_on;
    logic [1:0] turn_select;
    logic       beacon_on;
    logic       siren_on;
  } vlss_in_t;

  typedef struct packed {
    logic left_lamp;
    logic right_lamp;
    logic beacon_left;
    logic beacon_right;
    logic beacon_center;
    logic tone_main;
    logic tone_second;
    logic clear_turn;
  } vlss_out_t;

  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd2;

  localparam logic [6:0] HAZ_ON_AT  = 7'd40;
  localparam logic [6:0] HAZ_OFF_AT = 7'd80;
  localparam logic [5:0] TURN_AT    = 6'd40;

  localparam logic [6:0] PAT_A_WRAP = 7'd84;
  localparam logic [6:0] PAT_B_WRAP = 7'd90;

  localparam logic [10:0] SIREN_MAIN_AT   = 11'd1;
  localparam logic [10:0] SIREN_SECOND_AT = 11'd600;
  localparam logic [10:0] SIREN_END_AT    = 11'd1700;

endpackage

@@ src/vehicle_lamp_siren_sequencer_top.sv @@
// A beat waits in the input register, then its result from vlss_core is registered and offered.
// Throughput: one tick per cycle while results are taken; the input register advances whenever
// the result register is empty or being taken, so both sides may stall independently.
// Reset (synchronous, active high) clears all counters, lamp and tone levels
// and both valid flags.
// Depends on vlss_pkg, vlss_core and vehicle_lamp_siren_sequencer_top_macros.svh.
`include "vehicle_lamp_siren_sequencer_top_macros.svh"

module vehicle_lamp_siren_sequencer_top
  import vlss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  vlss_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output vlss_out_t result
);

  logic      stage_valid;
  vlss_in_t  stage;
  logic      advance;
  vlss_out_t core_result;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  vlss_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) stage_valid <= item_valid;
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) stage <= item;
    if (advance) result <= core_result;
  end

  `VLSS_ASSERT_SAME(a_ready_only_when_full, !item_ready,
    stage_valid && result_valid && !result_ready, "input stalled without a full pipe")
  `VLSS_ASSERT_NEXT(a_advance_fills_result, advance, result_valid, "advanced beat lost")
  `VLSS_ASSERT_SAME(a_second_needs_main, result_valid && result.tone_second,
    result.tone_main, "second tone without main tone")
  `VLSS_ASSERT_SAME(a_beacons_exclusive, result_valid,
    !(result.beacon_left && result.beacon_right), "left and right beacons both on")

endmodule

@@ src/vlss_core.sv @@
// Counter state, compare points and overrides for one tick of the sequencer.
// Depends on vlss_pkg.
module vlss_core
  import vlss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  vlss_in_t  item,
  output vlss_out_t result
);

  logic [6:0]  hazard_count, hazard_count_next;
  logic [5:0]  right_count, right_count_next;
  logic [5:0]  left_count, left_count_next;
  logic [6:0]  pattern_a_count, pattern_a_count_next;
  logic [6:0]  pattern_b_count, pattern_b_count_next;
  logic [10:0] siren_count, siren_count_next;
  vlss_out_t   pins, pins_next;

  always_comb begin
    logic [6:0]  hc;
    logic [5:0]  rc;
    logic [5:0]  lc;
    logic [6:0]  a;
    logic [6:0]  b;
    logic [10:0] sc;

    pins_next = pins;
    pins_next.clear_turn = item.hazard_on;

    hc = item.hazard_on ? hazard_count + 7'd1 : hazard_count;
    hazard_count_next = hc;
    if (hc == HAZ_ON_AT) begin
      pins_next.left_lamp  = 1'b1;
      pins_next.right_lamp = 1'b1;
    end
    if (hc == HAZ_OFF_AT) begin
      pins_next.left_lamp  = 1'b0;
      pins_next.right_lamp = 1'b0;
      hazard_count_next    = '0;
    end

    rc = (!item.hazard_on && item.turn_select == TURN_RIGHT) ? right_count + 6'd1 : right_count;
    right_count_next = rc;
    if (rc == TURN_AT) begin
      pins_next.right_lamp = ~pins_next.right_lamp;
      right_count_next     = '0;
    end

    lc = (!item.hazard_on && item.turn_select == TURN_LEFT) ? left_count + 6'd1 : left_count;
    left_count_next = lc;
    if (lc == TURN_AT) begin
      pins_next.left_lamp = ~pins_next.left_lamp;
      left_count_next     = '0;
    end

    a = item.beacon_on ? pattern_a_count + 7'd1 : pattern_a_count;
    pattern_a_count_next = a;
    if (a == 7'd1 || a == 7'd15 || a == 7'd29) pins_next.beacon_left = 1'b1;
    if (a == 7'd8 || a == 7'd22 || a == 7'd36) pins_next.beacon_left = 1'b0;
    if (a == 7'd43 || a == 7'd57 || a == 7'd71) pins_next.beacon_right = 1'b1;
    if (a == 7'd50 || a == 7'd64 || a == 7'd78) pins_next.beacon_right = 1'b0;
    if (a == PAT_A_WRAP) pattern_a_count_next = '0;

    b = item.beacon_on ? pattern_b_count + 7'd1 : pattern_b_count;
    pattern_b_count_next = b;
    if (b == 7'd10 || b == 7'd30 || b == 7'd50) pins_next.beacon_center = 1'b1;
    if (b == 7'd20 || b == 7'd40 || b == 7'd60) pins_next.beacon_center = 1'b0;
    if (b == PAT_B_WRAP) pattern_b_count_next = '0;

    sc = siren_count + 11'd1;
    siren_count_next = '0;
    if (item.siren_on) begin
      siren_count_next = sc;
      if (sc == SIREN_MAIN_AT) pins_next.tone_main = 1'b1;
      if (sc == SIREN_SECOND_AT) begin
        pins_next.tone_main   = 1'b1;
        pins_next.tone_second = 1'b1;
      end
      if (sc == SIREN_END_AT) begin
        pins_next.tone_second = 1'b0;
        siren_count_next      = '0;
      end
    end

    if (!item.hazard_on && item.turn_select == TURN_NONE) begin
      pins_next.left_lamp  = 1'b0;
      pins_next.right_lamp = 1'b0;
    end
    if (!item.beacon_on) begin
      pins_next.beacon_left   = 1'b0;
      pins_next.beacon_right  = 1'b0;
      pins_next.beacon_center = 1'b0;
    end
    if (!item.siren_on) begin
      pins_next.tone_main   = 1'b0;
      pins_next.tone_second = 1'b0;
    end
  end

  assign result = pins_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hazard_count    <= '0;
      right_count     <= '0;
      left_count      <= '0;
      pattern_a_count <= '0;
      pattern_b_count <= '0;
      siren_count     <= '0;
      pins            <= '0;
    end else if (step) begin
      hazard_count    <= hazard_count_next;
      right_count     <= right_count_next;
      left_count      <= left_count_next;
      pattern_a_count <= pattern_a_count_next;
      pattern_b_count <= pattern_b_count_next;
      siren_count     <= siren_count_next;
      pins            <= pins_next;
    end
  end

endmodule
